@@ src/tli_pkg.sv @@
// Shared types and constants of the breakpoint table interpolator.
// Used by every module of the block; depends on nothing.
package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENERGY_W    = 32;
    localparam int VALUE_W     = 17;
    localparam int PROD_W      = ENERGY_W + VALUE_W;
    localparam int QCNT_W      = $clog2(VALUE_W + 1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic                kind;
        logic [5:0]          point_index;
        logic [ENERGY_W-1:0] energy;
        logic [VALUE_W-1:0]  point_value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        status_t            status;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_EMPTY = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t            op;
        logic [IDX_W-1:0]    idx;
        logic [ENERGY_W-1:0] energy;
        logic [VALUE_W-1:0]  value;
    } op_t;

    // Handshake between the queue and the engine.
    typedef struct packed {
        logic valid;
        op_t  item;
    } queue_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } eng_state_t;

endpackage

@@ src/tli_front.sv @@
// Front part: accepts requests, classifies them and holds them in a
// two-entry queue for the engine. Depends on tli_pkg.
module tli_front import tli_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    input  logic [CNT_W-1:0] points_in_use,
    output queue_out_t       q_out,
    input  logic             q_pop
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    op_t        op_in;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;

    always_comb begin
        op_in.idx    = s_data.point_index[IDX_W-1:0];
        op_in.energy = s_data.energy;
        op_in.value  = s_data.point_value;
        if (s_data.kind == KIND_LOAD) begin
            op_in.op = OP_LOAD;
        end else if (points_in_use == '0) begin
            op_in.op = OP_EMPTY;
        end else begin
            op_in.op = OP_QUERY;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

@@ src/tli_divider.sv @@
// Restoring divider, one quotient bit per cycle, for a quotient known to
// fit in VALUE_W bits. Depends on tli_pkg.
module tli_divider import tli_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [ENERGY_W-1:0] divisor,
    output logic                done,
    output logic [VALUE_W-1:0]  quotient
);

    logic [ENERGY_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0]  lo_reg, lo_next;
    logic [ENERGY_W-1:0] div_reg, div_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ENERGY_W:0]   trial;
    logic                fits;

    always_comb begin
        trial     = {rem_reg, lo_reg[VALUE_W-1]};
        fits      = (trial >= {1'b0, div_reg});
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // The upper part is already below the divisor since off < span.
            rem_next  = dividend[PROD_W-1:VALUE_W];
            lo_next   = dividend[VALUE_W-1:0];
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? ENERGY_W'(trial - {1'b0, div_reg}) : trial[ENERGY_W-1:0];
            lo_next  = {lo_reg[VALUE_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

@@ src/tli_engine.sv @@
// Back part: breakpoint memory, linear search, multiply, divide and the
// output register. Depends on tli_pkg and tli_divider.
module tli_engine import tli_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  queue_out_t       q_in,
    output logic             q_pop,
    input  logic [CNT_W-1:0] points_in_use,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    logic [ENERGY_W-1:0] mem_e [TABLE_DEPTH];
    logic [VALUE_W-1:0]  mem_v [TABLE_DEPTH];
    logic [ENERGY_W-1:0] rd_e_reg;
    logic [VALUE_W-1:0]  rd_v_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;

    eng_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    n_eff;
    logic [ENERGY_W-1:0] e_reg, e_next;
    logic [ENERGY_W-1:0] prev_e_reg, prev_e_next;
    logic [VALUE_W-1:0]  prev_v_reg, prev_v_next;
    logic [ENERGY_W-1:0] off_reg, off_next;
    logic [ENERGY_W-1:0] span_reg, span_next;
    logic [VALUE_W-1:0]  diff_reg, diff_next;
    logic                down_reg, down_next;
    logic [PROD_W-1:0]   prod_reg;
    out_item_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;
    logic                div_start;
    logic                div_done;
    logic [VALUE_W-1:0]  div_q;
    logic [CNT_W-1:0]    cnt_inc;

    tli_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign n_eff   = (points_in_use > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : points_in_use;
    assign cnt_inc = cnt_reg + 1'b1;

    // The scan keeps one read in flight: while entry cnt is compared, the
    // next entry is being read.
    assign rd_addr   = (state_reg == S_SCAN) ? cnt_inc[IDX_W-1:0] : '0;
    assign wr_en     = (state_reg == S_IDLE) && q_in.valid && (q_in.item.op == OP_LOAD);
    assign div_start = (state_reg == S_DIV_GO);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_e[q_in.item.idx] <= q_in.item.energy;
            mem_v[q_in.item.idx] <= q_in.item.value;
        end
        rd_e_reg <= mem_e[rd_addr];
        rd_v_reg <= mem_v[rd_addr];
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        e_next       = e_reg;
        prev_e_next  = prev_e_reg;
        prev_v_next  = prev_v_reg;
        off_next     = off_reg;
        span_next    = span_reg;
        diff_next    = diff_reg;
        down_next    = down_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_in.valid) begin
                    q_pop  = 1'b1;
                    e_next = q_in.item.energy;
                    cnt_next = '0;
                    case (q_in.item.op)
                        OP_QUERY: state_next = S_SCAN;
                        OP_EMPTY: begin
                            res_next.result_value = '0;
                            res_next.status       = ST_EMPTY;
                            state_next            = S_OUT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_e_reg > e_reg) begin
                    if (cnt_reg == '0) begin
                        res_next.result_value = rd_v_reg;
                        res_next.status       = ST_BELOW;
                        state_next            = S_OUT;
                    end else begin
                        off_next  = e_reg - prev_e_reg;
                        span_next = rd_e_reg - prev_e_reg;
                        down_next = (rd_v_reg < prev_v_reg);
                        diff_next = (rd_v_reg < prev_v_reg) ? prev_v_reg - rd_v_reg
                                                           : rd_v_reg - prev_v_reg;
                        state_next = S_MUL;
                    end
                end else begin
                    prev_e_next = rd_e_reg;
                    prev_v_next = rd_v_reg;
                    if (cnt_inc == n_eff) begin
                        res_next.result_value = rd_v_reg;
                        res_next.status       = ST_ABOVE;
                        state_next            = S_OUT;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            S_MUL:    state_next = S_DIV_GO;
            S_DIV_GO: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    res_next.result_value = down_reg ? prev_v_reg - div_q
                                                     : prev_v_reg + div_q;
                    res_next.status       = ST_INTERP;
                    state_next            = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg      <= e_next;
        prev_e_reg <= prev_e_next;
        prev_v_reg <= prev_v_next;
        off_reg    <= off_next;
        span_reg   <= span_next;
        diff_reg   <= diff_next;
        down_reg   <= down_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        prod_reg   <= off_reg * diff_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/table_linear_interpolator_core.sv @@
// Piecewise linear interpolator over a 64-entry breakpoint table. A load
// request is written into the table straight from the idle state. A query
// walks the table one entry per cycle until it finds the first breakpoint
// above the energy or reaches the last breakpoint in use; its time is set
// by the linear scan of the breakpoint memory and the bit-serial divide,
// and an empty table answers without a scan. A two-entry queue sits in
// front of the engine and an output register behind it. The table memory
// has no reset: breakpoints must be loaded before queries reach them.
// Depends on tli_pkg, tli_front and tli_engine.
module table_linear_interpolator_core import tli_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0] points_reg;
    queue_out_t       q_out;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= '0;
        end else if (cfg_valid) begin
            points_reg <= cfg_data;
        end
    end

    tli_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .points_in_use (points_reg),
        .q_out         (q_out),
        .q_pop         (q_pop)
    );

    tli_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_in          (q_out),
        .q_pop         (q_pop),
        .points_in_use (points_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
